// ===== hdl/handle_table_free_list_unit_defines.svh =====
// Assertion macros used by the htfl_ctrl module.
`ifndef HANDLE_TABLE_FREE_LIST_UNIT_DEFINES_SVH
`define HANDLE_TABLE_FREE_LIST_UNIT_DEFINES_SVH

// The antecedent and the consequent are checked in the same cycle.
`define HTFL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define HTFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/htfl_pkg.sv =====
`default_nettype none

package htfl_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 256;
  localparam int unsigned HANDLE_W        = 12;
  localparam int unsigned OBJ_W           = 64;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned RES_IDX_W       = 8;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned IN_DATA_W       = 80;
  localparam int unsigned OUT_DATA_W      = 80;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 2'd0,
    OP_REL_HANDLE = 2'd1,
    OP_REL_OBJECT = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_INVALID   = 3'd2,
    STAT_NOT_ALLOC = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/handle_table_free_list_unit.sv =====
// Allocate, release by handle and lookup read their slot, then register the result
// from ST_EVAL; requests rejected for a null object, a bad handle or a full table
// register it from ST_IDLE. Release by object scans one slot a cycle from slot 0 up
// to a match or the last slot. Items are taken one at a time. A result that finds
// the output register full is parked and holds tready low. After reset a clearing
// sweep of all slots builds the free list; tready is low.
`default_nettype none

module handle_table_free_list_unit import htfl_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // handle_index [11:0], object_ref [75:12], zero fill above.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op [1:0].
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status [2:0], result_index [10:3], result_object [74:11], zero fill above.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned LINK_W = $clog2(ENTRIES + 2);
  localparam int unsigned OUT_USED_W = STATUS_W + RES_IDX_W + OBJ_W;

  mem_cmd_t              mem_cmd;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [LINK_W-1:0]     wr_link, link_rd;
  logic [OBJ_W-1:0]      wr_obj, obj_rd;
  logic [STATUS_W-1:0]   out_status;
  logic [RES_IDX_W-1:0]  out_index;
  logic [OBJ_W-1:0]      out_obj;

  htfl_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_handle_i  (s_axis_tdata[HANDLE_W-1:0]),
    .in_obj_i     (s_axis_tdata[HANDLE_W +: OBJ_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_index_o  (out_index),
    .out_obj_o    (out_obj),
    .mem_cmd_o    (mem_cmd),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .wr_link_o    (wr_link),
    .wr_obj_o     (wr_obj),
    .link_rd_i    (link_rd),
    .obj_rd_i     (obj_rd)
  );

  htfl_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_link_i (wr_link),
    .wr_obj_i  (wr_obj),
    .link_rd_o (link_rd),
    .obj_rd_o  (obj_rd)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_obj, out_index, out_status};

endmodule

`default_nettype wire

// ===== hdl/htfl_table.sv =====
`default_nettype none

module htfl_table import htfl_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned LINK_W = $clog2(ENTRIES + 2)
) (
  input  wire logic              clk_i,
  input  wire mem_cmd_t          cmd_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  input  wire logic [IDX_W-1:0]  wr_addr_i,
  input  wire logic [LINK_W-1:0] wr_link_i,
  input  wire logic [OBJ_W-1:0]  wr_obj_i,
  output logic      [LINK_W-1:0] link_rd_o,
  output logic      [OBJ_W-1:0]  obj_rd_o
);

  logic [LINK_W-1:0] link_mem [ENTRIES];
  logic [OBJ_W-1:0]  obj_mem  [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      link_mem[wr_addr_i] <= wr_link_i;
      obj_mem[wr_addr_i]  <= wr_obj_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      link_rd_o <= link_mem[rd_addr_i];
      obj_rd_o  <= obj_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/htfl_ctrl.sv =====
`default_nettype none

module htfl_ctrl import htfl_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES,
  localparam int unsigned IDX_W  = $clog2(ENTRIES),
  localparam int unsigned LINK_W = $clog2(ENTRIES + 2)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OP_W-1:0]   in_op_i,
  input  wire logic [HANDLE_W-1:0] in_handle_i,
  input  wire logic [OBJ_W-1:0]  in_obj_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [STATUS_W-1:0]    out_status_o,
  output logic [RES_IDX_W-1:0]   out_index_o,
  output logic [OBJ_W-1:0]       out_obj_o,
  output mem_cmd_t               mem_cmd_o,
  output logic [IDX_W-1:0]       rd_addr_o,
  output logic [IDX_W-1:0]       wr_addr_o,
  output logic [LINK_W-1:0]      wr_link_o,
  output logic [OBJ_W-1:0]       wr_obj_o,
  input  wire logic [LINK_W-1:0] link_rd_i,
  input  wire logic [OBJ_W-1:0]  obj_rd_i
);

`include "handle_table_free_list_unit_defines.svh"

  localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(ENTRIES);
  localparam logic [LINK_W-1:0] LINK_ALLOC = LINK_W'(ENTRIES + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(ENTRIES - 1);

  ctrl_state_e         state_q, state_d;
  op_e                 op_q, op_d, in_op;
  logic [OBJ_W-1:0]    obj_q, obj_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [LINK_W-1:0]   free_head_q, free_head_d;

  status_e             res_status_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [OBJ_W-1:0]    res_obj_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [OBJ_W-1:0]    out_obj_q;

  logic                fin;
  status_e             fin_status;
  logic [IDX_W-1:0]    fin_idx;
  logic [OBJ_W-1:0]    fin_obj;

  logic                out_free, out_load, res_load;
  logic                handle_bad, obj_null, table_full, obj_match;
  logic [IDX_W-1:0]    handle_addr;

  assign in_op       = op_e'(in_op_i);
  assign handle_bad  = ({1'b0, in_handle_i} >= (HANDLE_W + 1)'(ENTRIES));
  assign handle_addr = in_handle_i[IDX_W-1:0];
  assign obj_null    = (in_obj_i == '0);
  assign table_full  = (free_head_q == LINK_END);
  assign obj_match   = (obj_rd_i == obj_q);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    obj_d       = obj_q;
    idx_d       = idx_q;
    free_head_d = free_head_q;
    mem_cmd_o   = '0;
    rd_addr_o   = idx_q;
    wr_addr_o   = idx_q;
    wr_link_o   = LINK_ALLOC;
    wr_obj_o    = obj_q;
    in_ready_o  = 1'b0;
    fin         = 1'b0;
    fin_status  = STAT_OK;
    fin_idx     = '0;
    fin_obj     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_cmd_o.wr_en = 1'b1;
        wr_link_o       = LINK_W'(idx_q) + LINK_W'(1);
        wr_obj_o        = '0;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_op;
          obj_d = in_obj_i;
          unique case (in_op)
            OP_ALLOC: begin
              if (obj_null) begin
                fin        = 1'b1;
                fin_status = STAT_INVALID;
              end else if (table_full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else begin
                mem_cmd_o.rd_en = 1'b1;
                rd_addr_o       = free_head_q[IDX_W-1:0];
                idx_d           = free_head_q[IDX_W-1:0];
                state_d         = ST_EVAL;
              end
            end
            OP_REL_OBJECT: begin
              if (obj_null) begin
                fin        = 1'b1;
                fin_status = STAT_INVALID;
              end else begin
                mem_cmd_o.rd_en = 1'b1;
                rd_addr_o       = '0;
                idx_d           = '0;
                state_d         = ST_EVAL;
              end
            end
            OP_REL_HANDLE, OP_LOOKUP: begin
              if (handle_bad) begin
                fin        = 1'b1;
                fin_status = STAT_INVALID;
              end else begin
                mem_cmd_o.rd_en = 1'b1;
                rd_addr_o       = handle_addr;
                idx_d           = handle_addr;
                state_d         = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EVAL: begin
        unique case (op_q)
          OP_ALLOC: begin
            mem_cmd_o.wr_en = 1'b1;
            wr_link_o       = LINK_ALLOC;
            wr_obj_o        = obj_q;
            free_head_d     = link_rd_i;
            fin             = 1'b1;
            fin_idx         = idx_q;
          end
          OP_REL_HANDLE: begin
            fin = 1'b1;
            if (link_rd_i != LINK_ALLOC) begin
              fin_status = STAT_NOT_ALLOC;
            end else begin
              mem_cmd_o.wr_en = 1'b1;
              wr_link_o       = free_head_q;
              wr_obj_o        = '0;
              free_head_d     = LINK_W'(idx_q);
              fin_idx         = idx_q;
              fin_obj         = obj_rd_i;
            end
          end
          OP_REL_OBJECT: begin
            if (obj_match) begin
              fin = 1'b1;
              if (link_rd_i != LINK_ALLOC) begin
                fin_status = STAT_NOT_ALLOC;
              end else begin
                mem_cmd_o.wr_en = 1'b1;
                wr_link_o       = free_head_q;
                wr_obj_o        = '0;
                free_head_d     = LINK_W'(idx_q);
                fin_idx         = idx_q;
                fin_obj         = obj_q;
              end
            end else if (idx_q == LAST_IDX) begin
              fin        = 1'b1;
              fin_status = STAT_NOT_FOUND;
            end else begin
              mem_cmd_o.rd_en = 1'b1;
              rd_addr_o       = idx_q + IDX_W'(1);
              idx_d           = idx_q + IDX_W'(1);
            end
          end
          OP_LOOKUP: begin
            fin     = 1'b1;
            fin_idx = idx_q;
            fin_obj = obj_rd_i;
          end
          default: ;
        endcase
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  assign out_load = out_free && (fin || (state_q == ST_DONE));
  assign res_load = fin && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      free_head_q <= free_head_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    obj_q <= obj_d;
    if (res_load) begin
      res_status_q <= fin_status;
      res_idx_q    <= fin_idx;
      res_obj_q    <= fin_obj;
    end
    if (out_load) begin
      if (fin) begin
        out_status_q <= fin_status;
        out_idx_q    <= fin_idx;
        out_obj_q    <= fin_obj;
      end else begin
        out_status_q <= res_status_q;
        out_idx_q    <= res_idx_q;
        out_obj_q    <= res_obj_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_index_o  = RES_IDX_W'(out_idx_q);
  assign out_obj_o    = out_obj_q;

  `HTFL_ASSERT_SAME(a_head_in_range, 1'b1, free_head_q <= LINK_END, "free head out of range")
  `HTFL_ASSERT_SAME(a_alloc_from_free, (state_q == ST_EVAL) && (op_q == OP_ALLOC), link_rd_i != LINK_ALLOC, "free list head is an allocated slot")
  `HTFL_ASSERT_SAME(a_done_needs_busy, state_q == ST_DONE, out_valid_q, "result parked while output register is empty")
  `HTFL_ASSERT_NEXT(a_clear_ends, (state_q == ST_CLEAR) && (idx_q == LAST_IDX), (state_q == ST_IDLE) && (free_head_q == '0), "clearing sweep did not end cleanly")

endmodule

`default_nettype wire
